>>> sv/ecg_heart_rate_detector_unit_defines.svh
// ----------------------------------------------------------------------------
// ecg_heart_rate_detector_unit_defines.svh
// Assertion macros shared by the heart rate detector RTL.
// ----------------------------------------------------------------------------
`ifndef ECG_HEART_RATE_DETECTOR_UNIT_DEFINES_SVH
`define ECG_HEART_RATE_DETECTOR_UNIT_DEFINES_SVH

// Checked on every rising edge of clk, quiet while rst_n is low
`define EHRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included
`define EHRD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/ehrd_pkg.sv
// ----------------------------------------------------------------------------
// ehrd_pkg
// Widths, codes and constants of the heart rate detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ehrd_pkg;

  // Field widths
  localparam int SAMPLE_W   = 24;
  localparam int TIME_W     = 32;
  localparam int TIMEOUT_W  = 16;
  localparam int BEATS_W    = 4;
  localparam int RATE_W     = 13;
  localparam int PHASE_W    = 2;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_BEAT_THR  = 2'd0;
  localparam logic [1:0] REG_RESET_THR = 2'd1;
  localparam logic [1:0] REG_TIMEOUT   = 2'd2;
  localparam logic [1:0] REG_INIT_BEAT = 2'd3;

  // Register reset values
  localparam logic signed [SAMPLE_W-1:0] BEAT_THR_RST  = 24'sd500;
  localparam logic signed [SAMPLE_W-1:0] RESET_THR_RST = 24'sd5000000;
  localparam logic [TIMEOUT_W-1:0]       TIMEOUT_RST   = 16'd3000;
  localparam logic [BEATS_W-1:0]         INIT_BEAT_RST = 4'd3;

  // Peak search phases
  localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
  localparam logic [PHASE_W-1:0] PH_RISING  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_FALLING = 2'd2;

  // Beat interval limits (ms, exclusive) and rate numerator (60000 * 16)
  localparam logic [TIME_W-1:0] MIN_INTERVAL = 32'd200;
  localparam logic [TIME_W-1:0] MAX_INTERVAL = 32'd6000;
  localparam int                RATE_NUM     = 960000;
  localparam int                RATE_MAX     = 4800;

  // Divisor width: an accepted interval stays below 6000
  localparam int DEN_W      = 13;
  // Width of 960000 + interval/2
  localparam int RATE_DVD_W = 20;

  localparam int MEAN_WINDOW_DEF = 8;

endpackage

`default_nettype wire

>>> sv/ehrd_ram.sv
// ----------------------------------------------------------------------------
// ehrd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ehrd_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/ecg_heart_rate_detector_unit.sv
// ----------------------------------------------------------------------------
// ecg_heart_rate_detector_unit
// Threshold peak detector on lead II with beat interval to BPM conversion
// and a rolling mean of the rate.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake               Payload
//  in_      input      in_valid / in_stall     in_sample_uv, in_time_ms
//  out_     output     out_valid / out_stall   out_peak_found, out_rate_bpm_q4,
//                                              out_rate_valid
//  config   input      APB, pready tied high   paddr, pwdata, prdata
//
//  A sample without an accepted beat passes only through the evaluate and done
//  states. An accepted beat takes two passes through the one restoring divider
//  (interval to rate, then the window mean) plus sequencing states.
//  rst_n is synchronous; it clears the detector state and restores the
//  register defaults. The window RAM needs no clearing pass (fill count).
//  A stalled result is held in the output register; the next sample is
//  taken meanwhile and its result waits until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ecg_heart_rate_detector_unit_defines.svh"

module ecg_heart_rate_detector_unit
  import ehrd_pkg::*;
#(
  parameter int MEAN_WINDOW = MEAN_WINDOW_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // sample input
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [SAMPLE_W-1:0]  in_sample_uv,
  input  wire logic        [TIME_W-1:0]    in_time_ms,
  // result output
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_peak_found,
  output logic             [RATE_W-1:0]    out_rate_bpm_q4,
  output logic                             out_rate_valid,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic        [CFG_ADDR_W-1:0] paddr,
  input  wire logic        [CFG_DATA_W-1:0] pwdata,
  output logic             [CFG_DATA_W-1:0] prdata,
  output logic                             pready
);

  // Derived sizes
  localparam int FILL_W = $clog2(MEAN_WINDOW + 1);
  localparam int PTR_W  = (MEAN_WINDOW > 1) ? $clog2(MEAN_WINDOW) : 1;
  localparam int SUM_W  = $clog2(MEAN_WINDOW * RATE_MAX + MEAN_WINDOW / 2 + 1);
  localparam int DIV_W  = (SUM_W > RATE_DVD_W) ? SUM_W : RATE_DVD_W;
  localparam int CNT_W  = $clog2(DIV_W + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_PUSH = 3'd3;
  localparam logic [2:0] S_MEAN = 3'd4;
  localparam logic [2:0] S_DIV2 = 3'd5;
  localparam logic [2:0] S_PUB  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  // Configuration registers
  logic signed [SAMPLE_W-1:0] beat_thr_r;
  logic signed [SAMPLE_W-1:0] reset_thr_r;
  logic [TIMEOUT_W-1:0]       timeout_r;
  logic [BEATS_W-1:0]         init_beats_r;

  // Detector state
  logic [2:0]                 state_r, state_nxt;
  logic [PHASE_W-1:0]         phase_r, phase_nxt;
  logic [TIME_W-1:0]          peak_time_r, peak_time_nxt;
  logic [TIME_W-1:0]          last_beat_r, last_beat_nxt;
  logic signed [SAMPLE_W-1:0] prev_samp_r, prev_samp_nxt;
  logic [BEATS_W-1:0]         beat_cnt_r, beat_cnt_nxt;
  logic [RATE_W-1:0]          pub_rate_r, pub_rate_nxt;
  logic                       present_r, present_nxt;
  logic [FILL_W-1:0]          win_fill_r, win_fill_nxt;
  logic [SUM_W-1:0]           win_sum_r, win_sum_nxt;
  logic [PTR_W-1:0]           win_ptr_r, win_ptr_nxt;
  logic                       peak_r, peak_nxt;
  logic [CNT_W-1:0]           div_cnt_r, div_cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // Payload registers
  logic signed [SAMPLE_W-1:0] samp_r;
  logic [TIME_W-1:0]          now_r;
  logic [DIV_W-1:0]           div_num_r, div_num_nxt;
  logic [DEN_W-1:0]           div_rem_r, div_rem_nxt;
  logic [DEN_W-1:0]           div_den_r, div_den_nxt;
  logic                       out_peak_r;
  logic [RATE_W-1:0]          out_rate_r;
  logic                       out_present_r;

  // Datapath terms
  logic                       in_xfer;
  logic                       out_load;
  logic                       full_reset;
  logic                       timed_out;
  logic [TIME_W-1:0]          since_beat;
  logic [TIME_W-1:0]          interval;
  logic                       interval_ok;
  logic [DEN_W:0]             div_trial;
  logic [DEN_W:0]             div_diff;
  logic                       div_qbit;
  logic [RATE_W-1:0]          quotient;
  logic [RATE_W-1:0]          ram_rdata;
  logic                       win_full;
  logic [BEATS_W:0]           cnt_inc;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_thr_r   <= BEAT_THR_RST;
      reset_thr_r  <= RESET_THR_RST;
      timeout_r    <= TIMEOUT_RST;
      init_beats_r <= INIT_BEAT_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_BEAT_THR:  beat_thr_r   <= pwdata[SAMPLE_W-1:0];
        REG_RESET_THR: reset_thr_r  <= pwdata[SAMPLE_W-1:0];
        REG_TIMEOUT:   timeout_r    <= pwdata[TIMEOUT_W-1:0];
        REG_INIT_BEAT: init_beats_r <= pwdata[BEATS_W-1:0];
      endcase
    end
  end

  // Read back, thresholds sign extended
  always_comb begin
    unique case (paddr[3:2])
      REG_BEAT_THR:
        prdata = {{(CFG_DATA_W-SAMPLE_W){beat_thr_r[SAMPLE_W-1]}}, beat_thr_r};
      REG_RESET_THR:
        prdata = {{(CFG_DATA_W-SAMPLE_W){reset_thr_r[SAMPLE_W-1]}}, reset_thr_r};
      REG_TIMEOUT:   prdata = CFG_DATA_W'(timeout_r);
      REG_INIT_BEAT: prdata = CFG_DATA_W'(init_beats_r);
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign out_valid       = out_valid_r;
  assign out_peak_found  = out_peak_r;
  assign out_rate_bpm_q4 = out_rate_r;
  assign out_rate_valid  = out_present_r;

  // --------------------------------------------------------------------------
  // Sample evaluation terms
  // --------------------------------------------------------------------------
  assign full_reset  = (samp_r >= reset_thr_r);
  assign since_beat  = now_r - last_beat_r;
  assign timed_out   = (beat_cnt_r != '0) && (since_beat > TIME_W'(timeout_r));
  assign interval    = peak_time_r - last_beat_r;
  assign interval_ok = (interval > MIN_INTERVAL) && (interval < MAX_INTERVAL);

  // --------------------------------------------------------------------------
  // Shared restoring divider: one quotient bit per cycle
  // --------------------------------------------------------------------------
  assign div_trial = {div_rem_r, div_num_r[DIV_W-1]};
  assign div_diff  = div_trial - {1'b0, div_den_r};
  assign div_qbit  = (div_trial >= {1'b0, div_den_r});
  assign quotient  = div_num_r[RATE_W-1:0];

  // --------------------------------------------------------------------------
  // Rate window
  // --------------------------------------------------------------------------
  assign win_full = (win_fill_r == FILL_W'(MEAN_WINDOW));
  assign cnt_inc  = {1'b0, beat_cnt_r} + (BEATS_W+1)'(1);

  ehrd_ram #(
    .WIDTH (RATE_W),
    .DEPTH (MEAN_WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (state_r == S_PUSH),
    .waddr (win_ptr_r),
    .wdata (quotient),
    .raddr (win_ptr_r),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer and detector next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    peak_time_nxt = peak_time_r;
    last_beat_nxt = last_beat_r;
    prev_samp_nxt = prev_samp_r;
    beat_cnt_nxt  = beat_cnt_r;
    pub_rate_nxt  = pub_rate_r;
    present_nxt   = present_r;
    win_fill_nxt  = win_fill_r;
    win_sum_nxt   = win_sum_r;
    win_ptr_nxt   = win_ptr_r;
    peak_nxt      = peak_r;
    div_cnt_nxt   = div_cnt_r;
    div_num_nxt   = div_num_r;
    div_rem_nxt   = div_rem_r;
    div_den_nxt   = div_den_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        peak_nxt  = 1'b0;
        state_nxt = S_DONE;
        if (full_reset) begin
          phase_nxt     = PH_IDLE;
          peak_time_nxt = '0;
          last_beat_nxt = '0;
          prev_samp_nxt = '0;
          beat_cnt_nxt  = '0;
          pub_rate_nxt  = '0;
          present_nxt   = 1'b0;
          win_fill_nxt  = '0;
          win_sum_nxt   = '0;
          win_ptr_nxt   = '0;
        end else begin
          // no beat for too long: drop the rate
          if (timed_out) begin
            beat_cnt_nxt = '0;
            pub_rate_nxt = '0;
            present_nxt  = 1'b0;
            win_fill_nxt = '0;
            win_sum_nxt  = '0;
            win_ptr_nxt  = '0;
          end
          prev_samp_nxt = samp_r;
          priority if (phase_r == PH_IDLE) begin
            if (samp_r >= beat_thr_r) begin
              phase_nxt = PH_RISING;
            end
          end else if (phase_r == PH_RISING) begin
            if (samp_r > prev_samp_r) begin
              peak_time_nxt = now_r;
            end else begin
              // top of the beat; previous sample is kept
              prev_samp_nxt = prev_samp_r;
              last_beat_nxt = peak_time_r;
              phase_nxt     = PH_FALLING;
              peak_nxt      = 1'b1;
              if (interval_ok) begin
                div_num_nxt = DIV_W'(RATE_NUM) + DIV_W'(interval[DEN_W-1:1]);
                div_rem_nxt = '0;
                div_den_nxt = interval[DEN_W-1:0];
                div_cnt_nxt = CNT_W'(DIV_W);
                state_nxt   = S_DIV1;
              end
            end
          end else begin
            if (samp_r < beat_thr_r) begin
              phase_nxt = PH_IDLE;
            end
          end
        end
      end

      S_DIV1, S_DIV2: begin
        div_rem_nxt = div_qbit ? div_diff[DEN_W-1:0] : div_trial[DEN_W-1:0];
        div_num_nxt = {div_num_r[DIV_W-2:0], div_qbit};
        div_cnt_nxt = div_cnt_r - CNT_W'(1);
        if (div_cnt_r == CNT_W'(1)) begin
          state_nxt = (state_r == S_DIV1) ? S_PUSH : S_PUB;
        end
      end

      // new rate into the window, oldest out once full
      S_PUSH: begin
        if (win_full) begin
          win_sum_nxt = win_sum_r - SUM_W'(ram_rdata) + SUM_W'(quotient);
        end else begin
          win_sum_nxt  = win_sum_r + SUM_W'(quotient);
          win_fill_nxt = win_fill_r + FILL_W'(1);
        end
        win_ptr_nxt = (win_ptr_r == PTR_W'(MEAN_WINDOW - 1)) ? '0 : win_ptr_r + PTR_W'(1);
        state_nxt   = S_MEAN;
      end

      // mean rounded half up
      S_MEAN: begin
        div_num_nxt = DIV_W'(win_sum_r) + DIV_W'(win_fill_r >> 1);
        div_rem_nxt = '0;
        div_den_nxt = DEN_W'(win_fill_r);
        div_cnt_nxt = CNT_W'(DIV_W);
        state_nxt   = S_DIV2;
      end

      S_PUB: begin
        if (cnt_inc > {1'b0, init_beats_r}) begin
          pub_rate_nxt = quotient;
          present_nxt  = 1'b1;
          beat_cnt_nxt = init_beats_r;
        end else begin
          beat_cnt_nxt = cnt_inc[BEATS_W-1:0];
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  // Control and detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      peak_time_r <= '0;
      last_beat_r <= '0;
      prev_samp_r <= '0;
      beat_cnt_r  <= '0;
      pub_rate_r  <= '0;
      present_r   <= 1'b0;
      win_fill_r  <= '0;
      win_sum_r   <= '0;
      win_ptr_r   <= '0;
      peak_r      <= 1'b0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      peak_time_r <= peak_time_nxt;
      last_beat_r <= last_beat_nxt;
      prev_samp_r <= prev_samp_nxt;
      beat_cnt_r  <= beat_cnt_nxt;
      pub_rate_r  <= pub_rate_nxt;
      present_r   <= present_nxt;
      win_fill_r  <= win_fill_nxt;
      win_sum_r   <= win_sum_nxt;
      win_ptr_r   <= win_ptr_nxt;
      peak_r      <= peak_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: input capture, divider, result
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      samp_r <= in_sample_uv;
      now_r  <= in_time_ms;
    end
    div_num_r <= div_num_nxt;
    div_rem_r <= div_rem_nxt;
    div_den_r <= div_den_nxt;
    if (out_load) begin
      out_peak_r    <= peak_r;
      out_rate_r    <= pub_rate_r;
      out_present_r <= present_r;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `EHRD_ASSERT(a_no_rate_without_valid, (out_valid && !out_rate_valid) |-> (out_rate_bpm_q4 == '0), "rate shown while not valid")
  `EHRD_ASSERT(a_fill_bound, win_fill_r <= FILL_W'(MEAN_WINDOW), "window fill beyond depth")
  `EHRD_ASSERT(a_div_done, (state_r == S_PUSH || state_r == S_PUB) |-> (div_cnt_r == '0), "divider left before finishing")
  `EHRD_ASSERT(a_eval_follows, in_xfer |=> (state_r == S_EVAL), "accepted sample not evaluated")
  `EHRD_ASSERT(a_present_window, present_r |-> (win_fill_r != '0), "rate published with empty window")

endmodule

`default_nettype wire

>>> test/ecg_heart_rate_detector_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ecg_heart_rate_detector_unit_test
// Self-checking bench for the heart rate detector. Samples go in over the
// valid/stall channel, and every transfer is run through a local beat
// predictor. Each result transfer is compared field by field against the
// oldest predicted report. The directed tests cover the field extremes, the
// interval limits and the beat timeout. Random traffic made of random beats,
// noise and reset spikes then runs under several register settings and gap
// patterns.
// ----------------------------------------------------------------------------

module ecg_heart_rate_detector_unit_test;
  import ehrd_pkg::*;

  localparam int     CLK_HALF_NS   = 2;
  localparam int     RUN_LIMIT_NS  = 4_000_000;
  localparam int     SETTLE_CYCLES = 60;
  localparam int     MAX_REPORTED  = 10;
  localparam longint SAMPLE_MAX    = 8388607;
  localparam longint SAMPLE_MIN    = -8388608;

  typedef enum int {GAPS_RECV_HEAVY, GAPS_SEND_HEAVY, GAPS_NONE} gap_mode_t;

  typedef struct packed {
    logic              peak_found;
    logic [RATE_W-1:0] rate_bpm_q4;
    logic              rate_valid;
  } beat_report_t;

  // DUT signals
  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [SAMPLE_W-1:0]   in_sample_uv = '0;
  logic        [TIME_W-1:0]     in_time_ms = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         out_peak_found;
  logic        [RATE_W-1:0]     out_rate_bpm_q4;
  logic                         out_rate_valid;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic        [CFG_ADDR_W-1:0] paddr = '0;
  logic        [CFG_DATA_W-1:0] pwdata = '0;
  logic        [CFG_DATA_W-1:0] prdata;
  logic                         pready;

  // Bench bookkeeping
  beat_report_t pending_reports[$];
  int           mismatches = 0;
  int           samples_sent = 0;
  int           send_gap_pct = 0;
  int           stall_pct = 0;
  logic [TIME_W-1:0] beat_clock = '0;

  // Predictor copy of the registers
  logic signed [SAMPLE_W-1:0] cfg_beat_thr;
  logic signed [SAMPLE_W-1:0] cfg_reset_thr;
  logic [TIMEOUT_W-1:0]       cfg_timeout;
  logic [BEATS_W-1:0]         cfg_init_beats;

  // Predictor copy of the detector state
  logic [PHASE_W-1:0]         ph;
  logic [TIME_W-1:0]          pk_time;
  logic [TIME_W-1:0]          last_beat;
  logic signed [SAMPLE_W-1:0] prev_smp;
  logic [BEATS_W-1:0]         beat_cnt;
  logic [RATE_W-1:0]          pub_rate;
  logic                       rate_on;
  int unsigned                win [MEAN_WINDOW_DEF];
  int unsigned                win_fill;
  int unsigned                win_sum;
  int unsigned                win_ptr;

  ecg_heart_rate_detector_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_uv    (in_sample_uv),
    .in_time_ms      (in_time_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_peak_found  (out_peak_found),
    .out_rate_bpm_q4 (out_rate_bpm_q4),
    .out_rate_valid  (out_rate_valid),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Clock
  always begin
    clk = 1'b1;
    #(CLK_HALF_NS);
    clk = 1'b0;
    #(CLK_HALF_NS);
  end

  // ---------------------------------------------------------------------------
  // Beat predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_rate();
    beat_cnt = '0;
    pub_rate = '0;
    rate_on  = 1'b0;
    foreach (win[i]) win[i] = 0;
    win_fill = 0;
    win_sum  = 0;
    win_ptr  = 0;
  endfunction

  task automatic reset_model();
    cfg_beat_thr   = BEAT_THR_RST;
    cfg_reset_thr  = RESET_THR_RST;
    cfg_timeout    = TIMEOUT_RST;
    cfg_init_beats = INIT_BEAT_RST;
    ph        = PH_IDLE;
    pk_time   = '0;
    last_beat = '0;
    prev_smp  = '0;
    clear_rate();
  endtask

  // Rolling mean of the beat rate, rounded half up
  function automatic int unsigned push_window(input int unsigned bpm);
    if (win_fill < MEAN_WINDOW_DEF) win_fill++;
    else win_sum -= win[win_ptr];
    win_sum += bpm;
    win[win_ptr] = bpm;
    win_ptr = (win_ptr + 1 >= MEAN_WINDOW_DEF) ? 0 : win_ptr + 1;
    return (win_sum + win_fill / 2) / win_fill;
  endfunction

  function automatic beat_report_t detect_beat(input logic signed [SAMPLE_W-1:0] smp,
                                               input logic [TIME_W-1:0] now);
    beat_report_t rep;
    logic [TIME_W-1:0] iv;
    logic [BEATS_W:0]  next_cnt;
    int unsigned       bpm;
    int unsigned       avg;
    logic              peak;
    peak = 1'b0;
    rep  = '0;
    // Sample at reset level clears everything
    if (smp >= cfg_reset_thr) begin
      ph        = PH_IDLE;
      pk_time   = '0;
      last_beat = '0;
      prev_smp  = '0;
      clear_rate();
      return rep;
    end
    // No beat for too long
    if (beat_cnt != 0 && (now - last_beat) > {16'd0, cfg_timeout}) clear_rate();
    case (ph)
      PH_IDLE: begin
        if (smp >= cfg_beat_thr) ph = PH_RISING;
      end
      PH_RISING: begin
        if (smp > prev_smp) begin
          pk_time = now;
        end else begin
          iv = pk_time - last_beat;
          last_beat = pk_time;
          if (iv > MIN_INTERVAL && iv < MAX_INTERVAL) begin
            bpm = (RATE_NUM + iv / 2) / iv;
            avg = push_window(bpm);
            next_cnt = {1'b0, beat_cnt} + 1'b1;
            if (next_cnt > {1'b0, cfg_init_beats}) begin
              pub_rate = avg[RATE_W-1:0];
              rate_on  = 1'b1;
              beat_cnt = cfg_init_beats;
            end else begin
              beat_cnt = next_cnt[BEATS_W-1:0];
            end
          end
          ph   = PH_FALLING;
          peak = 1'b1;
        end
      end
      default: begin
        if (smp < cfg_beat_thr) ph = PH_IDLE;
      end
    endcase
    if (!peak) prev_smp = smp;
    rep.peak_found  = peak;
    rep.rate_bpm_q4 = pub_rate;
    rep.rate_valid  = rate_on;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [31:0] expv,
                                      input logic [31:0] actv);
    if (actv !== expv) begin
      mismatches++;
      if (mismatches <= MAX_REPORTED)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, expv, actv);
    end
  endfunction

  always @(posedge clk) begin
    beat_report_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTED)
            $display("%0t: result transfer with no report pending", $realtime);
        end else begin
          want = pending_reports.pop_front();
          check_field("peak_found", want.peak_found, out_peak_found);
          check_field("rate_bpm_q4", want.rate_bpm_q4, out_rate_bpm_q4);
          check_field("rate_valid", want.rate_valid, out_rate_valid);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  function automatic logic signed [SAMPLE_W-1:0] fit24(input longint v);
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    else if (v < SAMPLE_MIN) v = SAMPLE_MIN;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic set_gap_mode(input gap_mode_t mode);
    case (mode)
      GAPS_RECV_HEAVY: begin send_gap_pct = 6;  stall_pct = 59; end
      GAPS_SEND_HEAVY: begin send_gap_pct = 59; stall_pct = 6;  end
      default:         begin send_gap_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // One sample transfer; valid stays up afterwards unless a gap follows
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp,
                             input logic [TIME_W-1:0] stamp);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_uv <= smp;
    in_time_ms   <= stamp;
    do @(posedge clk); while (in_stall);
    pending_reports.push_back(detect_beat(smp, stamp));
    samples_sent++;
  endtask

  // Hold off the sender until every report has come back, then let the
  // longest beat computation run out
  task automatic wait_for_reports();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr[3:2])
      REG_BEAT_THR:  cfg_beat_thr   = data[SAMPLE_W-1:0];
      REG_RESET_THR: cfg_reset_thr  = data[SAMPLE_W-1:0];
      REG_TIMEOUT:   cfg_timeout    = data[TIMEOUT_W-1:0];
      REG_INIT_BEAT: cfg_init_beats = data[BEATS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic signed [SAMPLE_W-1:0] thr,
                                input logic signed [SAMPLE_W-1:0] rst,
                                input logic [TIMEOUT_W-1:0] tmo,
                                input logic [BEATS_W-1:0] ib);
    wait_for_reports();
    write_reg({REG_BEAT_THR, 2'b00}, 32'(thr));
    write_reg({REG_RESET_THR, 2'b00}, 32'(rst));
    write_reg({REG_TIMEOUT, 2'b00}, {16'd0, tmo});
    write_reg({REG_INIT_BEAT, 2'b00}, {28'd0, ib});
  endtask

  // Clean four-sample beat whose top lands iv ms after the previous one
  task automatic send_shaped_beat(input logic [TIME_W-1:0] iv);
    longint thr;
    thr = longint'(cfg_beat_thr);
    beat_clock = beat_clock + iv;
    send_sample(fit24(thr - 100), beat_clock - 4);
    send_sample(fit24(thr), beat_clock - 2);
    send_sample(fit24(thr + 1000), beat_clock);
    // equal level is not a rise, so this marks the peak
    send_sample(fit24(thr + 1000), beat_clock + 2);
  endtask

  // Beat with random shape and interval around the current thresholds
  task automatic send_random_beat();
    longint thr;
    longint lvl;
    int     rises;
    int     pick;
    logic [TIME_W-1:0] iv;
    logic [TIME_W-1:0] t;
    thr  = longint'(cfg_beat_thr);
    pick = $urandom_range(99);
    if (pick < 70)      iv = $urandom_range(2000, 250);
    else if (pick < 80) iv = $urandom_range(260, 150);
    else if (pick < 90) iv = $urandom_range(6100, 5900);
    else if (pick < 95) iv = $urandom_range(199);
    else                iv = $urandom();
    beat_clock = beat_clock + iv;
    rises = $urandom_range(3, 1);
    t = beat_clock - 2 * (rises + 1);
    // below the beat level first, so a falling phase returns to idle
    send_sample(fit24(thr - 1 - longint'($urandom_range(3000))), t);
    lvl = thr + longint'($urandom_range(400));
    send_sample(fit24(lvl), t + 2);
    for (int k = 0; k < rises; k++) begin
      lvl = lvl + longint'($urandom_range(4000, 1));
      send_sample(fit24(lvl), t + 4 + 2 * k);
    end
    // sometimes no drop: the next beat's first sample ends the rise
    if ($urandom_range(7) != 0)
      send_sample(fit24(lvl - longint'($urandom_range(4000))),
                  beat_clock + $urandom_range(4, 1));
    repeat ($urandom_range(2))
      send_sample(fit24(thr + longint'($urandom_range(300))),
                  beat_clock + $urandom_range(20, 5));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_field_extremes();
    send_sample(fit24(0), 32'h0000_0001);
    send_sample(fit24(SAMPLE_MAX), 32'hFFFF_FFFF);
    send_sample(fit24(SAMPLE_MIN), 32'h0000_0000);
    // exactly at the reset level
    send_sample(RESET_THR_RST, 32'h8000_0000);
  endtask

  task automatic test_interval_limits();
    apply_settings(BEAT_THR_RST, RESET_THR_RST, 16'hFFFF, 4'd1);
    beat_clock = 32'hFFFF_FE00;
    // huge interval from a zero last beat, then 200 and 6000 are both dropped
    send_shaped_beat(32'd0);
    send_shaped_beat(32'd200);
    send_shaped_beat(32'd201);
    send_shaped_beat(32'd5999);
    send_shaped_beat(32'd6000);
  endtask

  task automatic test_beat_timeout();
    send_sample(fit24(longint'(cfg_beat_thr) - 100), beat_clock + 32'd65536);
  endtask

  task automatic test_random_traffic();
    logic signed [SAMPLE_W-1:0] thr;
    logic signed [SAMPLE_W-1:0] rst;
    logic [TIMEOUT_W-1:0]       tmo;
    logic [BEATS_W-1:0]         ib;
    int        quota;
    int        pick;
    gap_mode_t mode;
    // start just short of the wrap of the millisecond count
    beat_clock = 32'hFFFF_0000 + $urandom_range(32'hFFFF);
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          thr = BEAT_THR_RST; rst = RESET_THR_RST; tmo = TIMEOUT_RST; ib = INIT_BEAT_RST;
          quota = 300; mode = GAPS_RECV_HEAVY;
        end
        1: begin
          thr = fit24(SAMPLE_MIN); rst = fit24(SAMPLE_MAX); tmo = 16'hFFFF; ib = 4'd15;
          quota = 300; mode = GAPS_RECV_HEAVY;
        end
        2: begin
          // lowered beat count after fifteen
          thr = fit24(longint'($urandom_range(4000)) - 2000);
          rst = fit24(longint'(thr) + longint'($urandom_range(8000000, 10000)));
          tmo = TIMEOUT_W'($urandom_range(8000, 1000)); ib = 4'd2;
          quota = 300; mode = GAPS_SEND_HEAVY;
        end
        3: begin
          thr = fit24(1000); rst = fit24(2000000); tmo = 16'd0; ib = 4'd0;
          quota = 300; mode = GAPS_SEND_HEAVY;
        end
        4: begin
          // every sample is at reset level
          thr = fit24(SAMPLE_MAX); rst = fit24(SAMPLE_MIN);
          tmo = TIMEOUT_W'($urandom_range(16'hFFFF)); ib = BEATS_W'($urandom_range(15));
          quota = 40; mode = GAPS_NONE;
        end
        default: begin
          thr = fit24(longint'($urandom_range(200000)) - 100000);
          rst = fit24(longint'(thr) + longint'($urandom_range(4000000, 1)));
          tmo = TIMEOUT_W'($urandom_range(16'hFFFF)); ib = BEATS_W'($urandom_range(15));
          quota = 360; mode = GAPS_NONE;
        end
      endcase
      apply_settings(thr, rst, tmo, ib);
      set_gap_mode(mode);
      quota += samples_sent;
      while (samples_sent < quota) begin
        pick = $urandom_range(99);
        if (pick < 80)
          send_random_beat();
        else if (pick < 83)
          send_sample(SAMPLE_W'($urandom()), $urandom());
        else if (pick < 96)
          send_sample(SAMPLE_W'($urandom()), beat_clock + $urandom_range(40));
        else
          send_sample(fit24(longint'(cfg_reset_thr) + longint'($urandom_range(1000))),
                      beat_clock + 3);
      end
    end
  endtask

  task automatic finish_run();
    wait_for_reports();
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("ecg_heart_rate_detector_unit_test passed");
    end else begin
      $display("ecg_heart_rate_detector_unit_test failed");
    end
    $finish;
  endtask

  // Main sequence
  initial begin
    reset_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_gap_mode(GAPS_RECV_HEAVY);
    test_field_extremes();
    test_interval_limits();
    test_beat_timeout();
    test_random_traffic();
    finish_run();
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("ecg_heart_rate_detector_unit_test failed");
    $finish;
  end

endmodule

>>> ecg_heart_rate_detector_unit.f
+incdir+sv
sv/ehrd_pkg.sv
sv/ehrd_ram.sv
sv/ecg_heart_rate_detector_unit.sv
test/ecg_heart_rate_detector_unit_test.sv
